// ----- src/stbs_pkg.sv -----
// shared types and constants for the sorted table binary search block
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int DATA_W      = 32;
    localparam int ENTRY_IDX_W = 10;
    localparam int ECOUNT_W    = 11;
    localparam int PROBE_W     = 4;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

    // word commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_FINISH
    } stbs_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic mem_wr;
        logic probe;
        logic step;
        logic finish;
    } stbs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic range_open;
        logic hit;
        logic out_busy;
    } stbs_stat_t;

endpackage

`default_nettype wire

// ----- src/stbs_ctrl.sv -----
// search sequencer state machine
`timescale 1ns / 1ps
`default_nettype none

module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       cmd,
    output logic            in_stall,
    input  wire stbs_stat_t ctrl_stat,
    output stbs_cmd_t       ctrl_cmd
);

    stbs_state_t state_reg;
    stbs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && cmd == CMD_SEARCH)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = ctrl_stat.range_open ? ST_COMPARE : ST_FINISH;
            end
            ST_COMPARE:
            begin
                state_next = ctrl_stat.hit ? ST_FINISH : ST_PROBE;
            end
            ST_FINISH:
            begin
                if (!ctrl_stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl_cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall        = 1'b0;
                ctrl_cmd.start  = in_valid && cmd == CMD_SEARCH;
                ctrl_cmd.mem_wr = in_valid && cmd == CMD_WRITE;
            end
            ST_PROBE:
            begin
                ctrl_cmd.probe = ctrl_stat.range_open;
            end
            ST_COMPARE:
            begin
                ctrl_cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                ctrl_cmd.finish = !ctrl_stat.out_busy;
            end
            default:
            begin
                ctrl_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_start_probes: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.start |=> state_reg == ST_PROBE)
        else $error("search start did not enter probe state");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.finish |-> !ctrl_stat.out_busy)
        else $error("result loaded over a word still waiting");

    a_probe_then_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.probe |=> ctrl_cmd.step)
        else $error("memory read not followed by compare");
`endif

endmodule

`default_nettype wire

// ----- src/stbs_dp.sv -----
// table memory, search bounds and result register
`timescale 1ns / 1ps
`default_nettype none

module stbs_dp
    import stbs_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire stbs_cmd_t               ctrl_cmd,
    output stbs_stat_t                   ctrl_stat,
    input  wire logic [ECOUNT_W-1:0]     entry_count,
    input  wire logic [ENTRY_IDX_W-1:0]  entry_index,
    input  wire logic signed [DATA_W-1:0] item_value,
    input  wire logic                    out_stall,
    output logic                         out_valid,
    output logic                         found,
    output logic [ENTRY_IDX_W-1:0]       match_index,
    output logic [PROBE_W-1:0]           probe_count
);

    logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [CNT_W-1:0]         left_reg;
    logic [CNT_W-1:0]         hi_reg;       // one past the last candidate
    logic [IDX_W-1:0]         mid_reg;
    logic [PROBE_W-1:0]       probes_reg;
    logic                     hit_reg;

    logic                     out_valid_reg;
    logic                     found_reg;
    logic [ENTRY_IDX_W-1:0]   match_reg;
    logic [PROBE_W-1:0]       probe_count_reg;

    logic [CNT_W:0]           mid_sum;
    logic [IDX_W-1:0]         mid;
    logic [CNT_W-1:0]         count_clamped;
    logic                     wr_in_range;

    assign mid_sum = {1'b0, left_reg} + {1'b0, hi_reg} - 1'b1;
    assign mid     = mid_sum[IDX_W:1];

    assign count_clamped = (CNT_W'(entry_count) > CNT_W'(TABLE_DEPTH)) ?
                           CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count);
    assign wr_in_range   = 32'(entry_index) < 32'(TABLE_DEPTH);

    assign ctrl_stat.range_open = left_reg < hi_reg;
    assign ctrl_stat.hit        = rdata_reg == key_reg;
    assign ctrl_stat.out_busy   = out_valid_reg && out_stall;

    // table memory, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.mem_wr && wr_in_range)
        begin
            table_mem[IDX_W'(entry_index)] <= item_value;
        end
        if (ctrl_cmd.probe)
        begin
            rdata_reg <= table_mem[mid];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.start)
        begin
            key_reg    <= item_value;
            left_reg   <= '0;
            hi_reg     <= count_clamped;
            probes_reg <= '0;
            hit_reg    <= 1'b0;
        end
        if (ctrl_cmd.probe)
        begin
            mid_reg <= mid;
        end
        if (ctrl_cmd.step)
        begin
            probes_reg <= (probes_reg == PROBE_MAX) ? probes_reg : probes_reg + 1'b1;
            if (rdata_reg == key_reg)
            begin
                hit_reg <= 1'b1;
            end
            else if (rdata_reg > key_reg)
            begin
                hi_reg <= CNT_W'(mid_reg);
            end
            else
            begin
                left_reg <= CNT_W'(mid_reg) + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl_cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.finish)
        begin
            found_reg       <= hit_reg;
            match_reg       <= hit_reg ? ENTRY_IDX_W'(mid_reg) : '0;
            probe_count_reg <= probes_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_reg;
    assign probe_count = probe_count_reg;

endmodule

`default_nettype wire

// ----- src/sorted_table_binary_search.sv -----
// top level of the sorted table binary search block
//
// holds a table of signed 32-bit entries (1024 deep) that software fills in
// ascending order, and answers searches for a key by binary search over
// entries 0 to entry_count-1 (entry_count above the table depth counts as the
// depth). a write word (cmd 0) stores item_value at entry_index and gives no
// result; an entry_index past the table is dropped. a search word (cmd 1)
// gives one result word: found, match_index (0 on a miss) and probe_count.
// each probe is a registered memory read followed by a compare against the
// key, and the input stalls while a search runs. the result sits in an output
// register, so the next word is taken while a result still waits. entries
// never written read back as garbage; the table has no reset. entry_count is
// set over the apb port at byte address 0; software must set it only while no
// search is running, the block itself does not enforce this
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // apb configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,

    // input words
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     cmd,
    input  wire logic [ENTRY_IDX_W-1:0]   entry_index,
    input  wire logic signed [DATA_W-1:0] item_value,

    // result words
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          found,
    output logic [ENTRY_IDX_W-1:0]        match_index,
    output logic [PROBE_W-1:0]            probe_count
);

    logic [ECOUNT_W-1:0] entry_count_reg;
    logic [ECOUNT_W-1:0] entry_count_next;
    logic                reg_sel;
    logic                cfg_wr;

    stbs_cmd_t  ctrl_cmd;
    stbs_stat_t ctrl_stat;

    // register index is the word address; only entry_count exists
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (cfg_wr && reg_sel == REG_ENTRY_COUNT)
        begin
            entry_count_next = pwdata[ECOUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    // readback, zero beyond the register list
    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_ENTRY_COUNT)
        begin
            prdata = APB_DATA_W'(entry_count_reg);
        end
    end

    // sequencer: idle, probe read, compare, result load
    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .ctrl_stat (ctrl_stat),
        .ctrl_cmd  (ctrl_cmd)
    );

    // table memory, left / upper bounds, probe counter and output register
    stbs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_cmd    (ctrl_cmd),
        .ctrl_stat   (ctrl_stat),
        .entry_count (entry_count_reg),
        .entry_index (entry_index),
        .item_value  (item_value),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .found       (found),
        .match_index (match_index),
        .probe_count (probe_count)
    );

endmodule

`default_nettype wire

// ----- tb/stbs_search_checker.sv -----
// checker for the sorted table binary search block: mirrors the table and predicts each search
`timescale 1ns / 1ps

module stbs_search_checker
    import stbs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0]    pwdata,
    input  wire logic [APB_DATA_W-1:0]    prdata,
    input  wire logic                     pready,

    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic                     cmd,
    input  wire logic [ENTRY_IDX_W-1:0]   entry_index,
    input  wire logic signed [DATA_W-1:0] item_value,

    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic                     found,
    input  wire logic [ENTRY_IDX_W-1:0]   match_index,
    input  wire logic [PROBE_W-1:0]       probe_count,

    output int                            mismatch_count,
    output int                            pending
);

    typedef struct packed {
        logic                   found;
        logic [ENTRY_IDX_W-1:0] match_index;
        logic [PROBE_W-1:0]     probe_count;
    } search_result_t;

    logic signed [DATA_W-1:0] entry_mem [TABLE_DEPTH];
    logic [ECOUNT_W-1:0]      entry_count_q;
    search_result_t           awaited_results [$];

    // binary search over the mirrored table, same probe order as the block
    function automatic search_result_t predict_search(input logic signed [DATA_W-1:0] key);
        search_result_t r;
        int span;
        int lo;
        int hi;
        int mid;
        int probes;
        span = (entry_count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_q);
        lo = 0;
        hi = span - 1;
        probes = 0;
        r.found = 1'b0;
        r.match_index = '0;
        while (lo <= hi && !r.found)
        begin
            mid = (lo + hi) / 2;
            if (probes < int'(PROBE_MAX))
                probes++;
            if (entry_mem[mid] == key)
            begin
                r.found = 1'b1;
                r.match_index = mid[ENTRY_IDX_W-1:0];
            end
            else if (entry_mem[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        r.probe_count = probes[PROBE_W-1:0];
        return r;
    endfunction

    function automatic void note_mismatch(input search_result_t want, input search_result_t got);
        if (mismatch_count < 10)
            $display("%0t result mismatch: expected found %0b index %0d probes %0d, got %0b %0d %0d",
                     $realtime, want.found, want.match_index, want.probe_count,
                     got.found, got.match_index, got.probe_count);
        mismatch_count++;
    endfunction

    always @(posedge clk)
    begin
        search_result_t got;
        search_result_t want;
        if (!rst_n)
        begin
            entry_count_q = '0;
            awaited_results.delete();
        end
        else
        begin
            // register access, write and read back
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_ENTRY_COUNT)
                        entry_count_q = pwdata[ECOUNT_W-1:0];
                end
                else if (paddr[2] == REG_ENTRY_COUNT &&
                         prdata !== APB_DATA_W'(entry_count_q))
                begin
                    if (mismatch_count < 10)
                        $display("%0t entry_count read mismatch: expected %0d, got %0h",
                                 $realtime, entry_count_q, prdata);
                    mismatch_count++;
                end
            end

            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_WRITE)
                    entry_mem[entry_index] = item_value;
                else
                    awaited_results.push_back(predict_search(item_value));
            end

            if (out_valid && !out_stall)
            begin
                got = '{found, match_index, probe_count};
                if (awaited_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t result word with none expected: found %0b index %0d probes %0d",
                                 $realtime, found, match_index, probe_count);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.found !== want.found || got.match_index !== want.match_index ||
                        got.probe_count !== want.probe_count)
                        note_mismatch(want, got);
                end
            end
        end
        pending <= awaited_results.size();
    end

endmodule

// ----- tb/sorted_table_binary_search_test.sv -----
// testbench top for the sorted table binary search block: stimulus, idling and verdict
`timescale 1ns / 1ps

module sorted_table_binary_search_test;
    import stbs_pkg::*;

    localparam int SETTLE_CYCLES = 32;    // a little over the slowest search
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int PHASES        = 12;
    localparam int KEY_TRIES     = 16;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic [APB_ADDR_W-1:0]    ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;

    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0]    pwdata = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     cmd = CMD_WRITE;
    logic [ENTRY_IDX_W-1:0]   entry_index = '0;
    logic signed [DATA_W-1:0] item_value = '0;

    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     found;
    logic [ENTRY_IDX_W-1:0]   match_index;
    logic [PROBE_W-1:0]       probe_count;

    int                       mismatch_total;
    int                       pending_results;

    // copy of what has been written, only used to pick search keys
    logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
    bit                       shadow_written [TABLE_DEPTH];
    bit                       no_idle = 1'b0;
    bit                       hold_off_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_table_binary_search i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .entry_index (entry_index),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .match_index (match_index),
        .probe_count (probe_count)
    );

    stbs_search_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .entry_index    (entry_index),
        .item_value     (item_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .match_index    (match_index),
        .probe_count    (probe_count),
        .mismatch_count (mismatch_total),
        .pending        (pending_results)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // random entry inside the span, the middle one if it was never written
    function automatic int pick_index(input int span);
        int k;
        k = $urandom_range(0, span - 1);
        if (!shadow_written[k])
            k = (span - 1) / 2;
        return k;
    endfunction

    // true when every entry the search for key would probe has been written
    function automatic bit probes_written(input logic signed [DATA_W-1:0] key, input int span);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = span - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (!shadow_written[mid])
                return 1'b0;
            if (shadow_table[mid] == key)
                return 1'b1;
            else if (shadow_table[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return 1'b1;
    endfunction

    // key mix: mostly hits, plus near misses, out of range and random keys
    function automatic logic signed [DATA_W-1:0] candidate_key(input int span);
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = pick_index(span);
        if (r < 50)
            return shadow_table[k];
        else if (r < 65)
            return shadow_table[k] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        else if (r < 80)
            return $urandom;
        else if (r < 87)
            return ($urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX);
        else if (r < 90)
            return '0;
        else if (r < 95)
            return shadow_table[0] - 32'sd1;
        else
            return shadow_table[span - 1] + 32'sd1;
    endfunction

    // a key whose probes stay on written entries, else a hit on the first probe
    function automatic logic signed [DATA_W-1:0] pick_key(input int span);
        logic signed [DATA_W-1:0] key;
        int                       tries;
        if (span == 0)
            return $urandom;
        for (tries = 0; tries < KEY_TRIES; tries++)
        begin
            key = candidate_key(span);
            if (probes_written(key, span))
                return key;
        end
        return shadow_table[(span - 1) / 2];
    endfunction

    // offer one word, hold it until taken
    task automatic send_word(input logic c, input logic [ENTRY_IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        entry_index <= idx;
        item_value  <= value;
        if (c == CMD_WRITE)
        begin
            shadow_table[idx] = value;
            shadow_written[idx] = 1'b1;
        end
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending, wait for every result, then let a trailing write finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // set entry_count and read it back
    task automatic set_entry_count(input int n);
        reg_access(1'b1, ADDR_ENTRY_COUNT, APB_DATA_W'(n));
        reg_access(1'b0, ADDR_ENTRY_COUNT, '0);
    endtask

    // ascending table over entries 0..span-1, three flavors of spacing
    task automatic fill_sorted(input int span);
        longint          level;
        longint unsigned stride;
        int unsigned     step_cap;
        int              start;
        int              k;
        start = $urandom;
        case ($urandom_range(0, 2))
            0:
            begin
                // from the bottom of the range, saturating at the top
                level = -64'sd2147483648;
                stride = 64'd8589934592 / span;
            end
            1:
            begin
                // dense, many equal entries
                level = start;
                stride = 3;
            end
            default:
            begin
                level = start;
                stride = 200000;
            end
        endcase
        step_cap = (stride > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : stride[31:0];
        for (k = 0; k < span; k++)
        begin
            send_word(CMD_WRITE, k[ENTRY_IDX_W-1:0], level[DATA_W-1:0]);
            level += longint'($urandom_range(0, step_cap));
            if (level > 64'sd2147483647)
                level = 64'sd2147483647;
        end
    endtask

    // large span: only the all-left and all-right probe paths are written,
    // values rise with the index so every such path stays sorted
    task automatic fill_paths(input int span);
        int lo;
        int hi;
        int mid;
        int level;
        lo = 0;
        hi = span - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            level = (mid - TABLE_DEPTH / 2) * 65536 + int'($urandom_range(0, 65535));
            send_word(CMD_WRITE, mid[ENTRY_IDX_W-1:0], level);
            hi = mid - 1;
        end
        lo = (span - 1) / 2 + 1;
        hi = span - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            level = (mid - TABLE_DEPTH / 2) * 65536 + int'($urandom_range(0, 65535));
            send_word(CMD_WRITE, mid[ENTRY_IDX_W-1:0], level);
            lo = mid + 1;
        end
    endtask

    // receiver: random stall runs, a free-running stretch when no_idle is set,
    // and one long hold-off on request so the block backs up into its input
    initial
    begin : receiver
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (no_idle)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n == 0)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int p;
        int k;
        int n;
        int span;
        int searches;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty range after reset: no probe at all
        reg_access(1'b0, ADDR_ENTRY_COUNT, '0);
        send_word(CMD_SEARCH, '0, VALUE_MIN);
        send_word(CMD_SEARCH, '1, VALUE_MAX);
        send_word(CMD_SEARCH, '0, '0);

        // small table holding both extremes, plus the last table slot
        send_word(CMD_WRITE, 10'd0, VALUE_MIN);
        send_word(CMD_WRITE, 10'd1, -32'sd5);
        send_word(CMD_WRITE, 10'd2, 32'sd0);
        send_word(CMD_WRITE, 10'd3, 32'sd7);
        send_word(CMD_WRITE, 10'd4, VALUE_MAX);
        send_word(CMD_WRITE, '1, 32'sh5A5A_A5A5);
        wait_idle();
        set_entry_count(5);

        // hits on every entry, then misses between and beside them
        send_word(CMD_SEARCH, '0, VALUE_MIN);
        send_word(CMD_SEARCH, '0, -32'sd5);
        send_word(CMD_SEARCH, '1, 32'sd0);
        send_word(CMD_SEARCH, '0, 32'sd7);
        send_word(CMD_SEARCH, '0, VALUE_MAX);
        send_word(CMD_SEARCH, '0, -32'sd6);
        send_word(CMD_SEARCH, '0, 32'sd1);
        send_word(CMD_SEARCH, '0, 32'sd8);

        // out-of-order entry: the probe sequence still decides the answer
        send_word(CMD_WRITE, 10'd2, 32'sd100);
        send_word(CMD_SEARCH, '0, 32'sd100);
        send_word(CMD_SEARCH, '0, 32'sd0);

        // random phases, each with its own entry_count, from the full table down
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       n = TABLE_DEPTH;
                1:       n = (1 << ECOUNT_W) - 1;    // all ones, clamps to the depth
                2:       n = TABLE_DEPTH + 1;
                3:       n = 1000;
                4:       n = 1;
                5:       n = 2;
                6:       n = 3;
                7:       n = 0;
                8:       n = 16;
                9:       n = 17;
                10:      n = $urandom_range(4, 64);
                default: n = $urandom_range(65, TABLE_DEPTH - 1);
            endcase
            span = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
            no_idle = ($urandom_range(0, 3) == 0);

            // small spans are filled whole, large ones along their edge paths;
            // search keys only ever lead to written entries
            if (span > 64)
                fill_paths(span);
            else if (span > 0)
                fill_sorted(span);
            wait_idle();
            set_entry_count(n);

            searches = (span == 0) ? 25 : 48;
            for (k = 0; k < searches; k++)
            begin
                if (p == 0 && k == 20)
                    hold_off_req = 1'b1;
                if (p == 3 && k == 30)
                    wait_idle();
                if ($urandom_range(0, 99) < 8)
                    send_word(CMD_WRITE, ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                              $urandom);
                else
                    send_word(CMD_SEARCH, ENTRY_IDX_W'($urandom), pick_key(span));
            end
        end

        wait_idle();
        if (mismatch_total == 0 && pending_results == 0)
            $display("PASS sorted_table_binary_search");
        else
            $display("FAIL sorted_table_binary_search");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin : watchdog
        #(40_000_000);
        $display("FAIL sorted_table_binary_search");
        $finish;
    end

endmodule

// ----- files.f -----
src/stbs_pkg.sv
src/stbs_ctrl.sv
src/stbs_dp.sv
src/sorted_table_binary_search.sv
tb/stbs_search_checker.sv
tb/sorted_table_binary_search_test.sv
